// ===== hdl/e2q_pkg.sv =====
`timescale 1ns / 1ps
package e2q_pkg;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int INNER_WIDTH_DEF  = 20;
  localparam int IO_W             = 16;
  localparam int TABLE_FRAC       = 30;
  localparam int TABLE_LEN        = 24;
  localparam int OUT_FRAC         = 14;
  localparam logic signed [IO_W-1:0] ONE_Q14 = 16'sd16384;

  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };
  localparam logic [31:0] GAIN_Q30    = 32'h26DD3B6A;
  localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;
  localparam logic [31:0] PI_Q30      = 32'hC90FDAA2;

  // round half up from 30 fractional bits to frac bits; shift left instead when frac >= 30
  function automatic logic [33:0] from_q30(input logic [31:0] v, input int frac);
    logic [33:0] w;
    w = {2'b00, v};
    if (frac >= TABLE_FRAC) return w << (frac - TABLE_FRAC);
    return (w + (34'd1 << (TABLE_FRAC - frac - 1))) >> (TABLE_FRAC - frac);
  endfunction
endpackage

// ===== hdl/e2q_if.sv =====
`timescale 1ns / 1ps
interface e2q_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2q_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ===== hdl/euler_to_quaternion_core.sv =====
`timescale 1ns / 1ps
// Euler (ZYX) angles to unit quaternion.
// in_ch : roll, pitch, yaw, signed Q2.13 radians, one item per handshake.
// out_ch: quat_x/y/z/w, signed Q1.14, rounded and saturated to +/-1.
// Every stage is a register; the pipeline is
//   1 range fold, CORDIC_STEPS (capped at TABLE_LEN) CORDIC stages, 1 sign fix,
//   1 pairwise product, 1 product rounding, 2 final product stages
//   (products then sums), 1 rounding and saturation into the output register.
// Throughput: one item per cycle while the output is not stalled, set by the fully unrolled CORDIC.
// The whole pipeline advances together; when the receiver holds off
// out_ch.ready with a full output register, every stage holds and
// in_ch.ready drops. Bubbles inside the pipeline hold with it: in_ch.ready
// is high exactly when the output register is free or being taken.
// Reset clears all valid bits; payload is left as is.
module euler_to_quaternion_core
  import e2q_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int INNER_WIDTH  = INNER_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  e2q_in_if.sink    in_ch,
  e2q_out_if.source out_ch
);
  localparam int W  = INNER_WIDTH;
  localparam int F  = INNER_WIDTH - 2;
  localparam int N  = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int NST = N + 7;

  localparam logic signed [W-1:0] HP  = W'(from_q30(HALF_PI_Q30, F));
  localparam logic signed [W-1:0] PIV = W'(from_q30(PI_Q30, F));
  localparam logic signed [W-1:0] KG  = W'(from_q30(GAIN_Q30, F));

  typedef logic signed [W-1:0] word_t;
  typedef word_t trip_t [3];

  logic [NST-1:0] vld_r;
  logic           adv;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  trip_t cx_r [N+1];
  trip_t cy_r [N+1];
  trip_t cz_r [N+1];
  logic [2:0] cf_r [N+1];

  // stage 0: fold half angle into +/- pi/2, seed the CORDIC
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [15:0] a;
        word_t h;
        a = (k == 0) ? in_ch.roll_angle : (k == 1) ? in_ch.pitch_angle : in_ch.yaw_angle;
        h = word_t'(a) <<< (F - 14);
        cx_r[0][k] <= KG;
        cy_r[0][k] <= '0;
        if (h > HP) begin
          cz_r[0][k] <= h - PIV;
          cf_r[0][k] <= 1'b1;
        end else if (h < -HP) begin
          cz_r[0][k] <= h + PIV;
          cf_r[0][k] <= 1'b1;
        end else begin
          cz_r[0][k] <= h;
          cf_r[0][k] <= 1'b0;
        end
      end
    end
  end

  // CORDIC stages
  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam word_t A = W'(from_q30(ATAN_Q30[i], F));
    always_ff @(posedge clk) begin
      if (adv) begin
        cf_r[i+1] <= cf_r[i];
        for (int k = 0; k < 3; k++) begin
          if (!cz_r[i][k][W-1]) begin
            cx_r[i+1][k] <= cx_r[i][k] - (cy_r[i][k] >>> i);
            cy_r[i+1][k] <= cy_r[i][k] + (cx_r[i][k] >>> i);
            cz_r[i+1][k] <= cz_r[i][k] - A;
          end else begin
            cx_r[i+1][k] <= cx_r[i][k] + (cy_r[i][k] >>> i);
            cy_r[i+1][k] <= cy_r[i][k] - (cx_r[i][k] >>> i);
            cz_r[i+1][k] <= cz_r[i][k] + A;
          end
        end
      end
    end
  end

  // sign fix: s/c per axis
  trip_t s_r, c_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s_r[k] <= cf_r[N][k] ? -cy_r[N][k] : cy_r[N][k];
        c_r[k] <= cf_r[N][k] ? -cx_r[N][k] : cx_r[N][k];
      end
    end
  end

  // pairwise products
  logic signed [PW-1:0] pcc_r, pcs_r, psc_r, pss_r;
  word_t sy1_r, cy1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pcc_r <= c_r[0] * c_r[1];
      pcs_r <= c_r[0] * s_r[1];
      psc_r <= s_r[0] * c_r[1];
      pss_r <= s_r[0] * s_r[1];
      sy1_r <= s_r[2];
      cy1_r <= c_r[2];
    end
  end

  function automatic word_t rnd_f(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v + (PW'(1) <<< (F - 1))) >>> F;
    return t[W-1:0];
  endfunction

  word_t crcp_r, crsp_r, srcp_r, srsp_r, sy2_r, cy2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      crcp_r <= rnd_f(pcc_r);
      crsp_r <= rnd_f(pcs_r);
      srcp_r <= rnd_f(psc_r);
      srsp_r <= rnd_f(pss_r);
      sy2_r  <= sy1_r;
      cy2_r  <= cy1_r;
    end
  end

  logic signed [PW-1:0] m_r [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0] <= srcp_r * cy2_r;
      m_r[1] <= crsp_r * sy2_r;
      m_r[2] <= crsp_r * cy2_r;
      m_r[3] <= srcp_r * sy2_r;
      m_r[4] <= crcp_r * sy2_r;
      m_r[5] <= srsp_r * cy2_r;
      m_r[6] <= crcp_r * cy2_r;
      m_r[7] <= srsp_r * sy2_r;
    end
  end

  logic signed [SW-1:0] q_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      q_r[0] <= SW'(m_r[0]) - SW'(m_r[1]);
      q_r[1] <= SW'(m_r[2]) + SW'(m_r[3]);
      q_r[2] <= SW'(m_r[4]) - SW'(m_r[5]);
      q_r[3] <= SW'(m_r[6]) + SW'(m_r[7]);
    end
  end

  function automatic logic signed [IO_W-1:0] out_f(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = (v + (SW'(1) <<< (2 * F - OUT_FRAC - 1))) >>> (2 * F - OUT_FRAC);
    if (t > SW'(ONE_Q14)) return ONE_Q14;
    if (t < -SW'(ONE_Q14)) return -ONE_Q14;
    return t[IO_W-1:0];
  endfunction

  logic signed [IO_W-1:0] qx_r, qy_r, qz_r, qw_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      qx_r <= out_f(q_r[0]);
      qy_r <= out_f(q_r[1]);
      qz_r <= out_f(q_r[2]);
      qw_r <= out_f(q_r[3]);
    end
  end
  assign out_ch.quat_x = qx_r;
  assign out_ch.quat_y = qy_r;
  assign out_ch.quat_z = qz_r;
  assign out_ch.quat_w = qw_r;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(qw_r))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("ready low with empty output");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (qw_r <= ONE_Q14) && (qw_r >= -ONE_Q14))
    else $error("w out of range");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted item lost");
`endif
endmodule

// ===== dv/tb_euler_to_quaternion_core.sv =====
`timescale 1ns / 1ps
module tb_euler_to_quaternion_core;
  import e2q_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int FRAC  = INNER_WIDTH_DEF - 2;
  localparam int LATENCY = STEPS + 7;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
  } quat_t;

  logic clk;
  logic rst_n;
  e2q_in_if  in_ch ();
  e2q_out_if out_ch ();

  euler_to_quaternion_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  angles_t pending_angles[$];
  quat_t   expected_quats[$];
  int      errors = 0;
  longint  cycle_count = 0;
  bit      hold_sender;
  bit      calm_sender;
  bit      calm_receiver;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_half_up(longint v, int s);
    if (s == 0) return v;
    return shr_floor(v + (longint'(1) << (s - 1)), s);
  endfunction

  function automatic longint q30_to_inner(longint v);
    return round_half_up(v, 30 - FRAC);
  endfunction

  function automatic void half_angle_sincos(input logic signed [15:0] ang,
                                            output longint s, output longint c);
    longint h, hp, pi, x, y, z, dx, dy, a;
    bit flip;
    int n;
    h = longint'(ang) * (longint'(1) << (FRAC - 14));
    hp = q30_to_inner(longint'(HALF_PI_Q30));
    pi = q30_to_inner(longint'(PI_Q30));
    flip = 0;
    n = STEPS < TABLE_LEN ? STEPS : TABLE_LEN;
    if (h > hp) begin
      h -= pi;
      flip = 1;
    end else if (h < -hp) begin
      h += pi;
      flip = 1;
    end
    x = q30_to_inner(longint'(GAIN_Q30));
    y = 0;
    z = h;
    for (int i = 0; i < n; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      a = q30_to_inner(longint'(ATAN_Q30[i]));
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= a;
      end else begin
        x += dx;
        y -= dy;
        z += a;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    longint r;
    r = round_half_up(v, 2 * FRAC - OUT_FRAC);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic quat_t angles_to_quat(angles_t a);
    longint sr, cr, sp, cp, sy, cy, crcp, crsp, srcp, srsp;
    quat_t q;
    half_angle_sincos(a.roll, sr, cr);
    half_angle_sincos(a.pitch, sp, cp);
    half_angle_sincos(a.yaw, sy, cy);
    crcp = round_half_up(cr * cp, FRAC);
    crsp = round_half_up(cr * sp, FRAC);
    srcp = round_half_up(sr * cp, FRAC);
    srsp = round_half_up(sr * sp, FRAC);
    q.x = to_q14(srcp * cy - crsp * sy);
    q.y = to_q14(crsp * cy + srcp * sy);
    q.z = to_q14(crcp * sy - srsp * cy);
    q.w = to_q14(crcp * cy + srsp * sy);
    return q;
  endfunction

  function automatic logic signed [15:0] rand_angle();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 16'($urandom);
    if (pick == 1) return 16'($urandom_range(25700, 25736));
    if (pick == 2) return -16'($urandom_range(25700, 25736));
    return 16'($urandom_range(0, 2 * 25736) - 25736);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_angles.size() != 0 && !hold_sender &&
          (calm_sender || $urandom_range(0, 99) >= 24)) begin
        angles_t a;
        a = pending_angles.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.roll_angle  <= a.roll;
        in_ch.pitch_angle <= a.pitch;
        in_ch.yaw_angle   <= a.yaw;
        expected_quats.push_back(angles_to_quat(a));
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_quats.size() == 0) begin
          $error("quaternion item with nothing expected");
          errors++;
        end else begin
          quat_t e;
          e = expected_quats.pop_front();
          if (out_ch.quat_x !== e.x) begin
            $error("quat_x expected %0d got %0d", e.x, out_ch.quat_x);
            errors++;
          end
          if (out_ch.quat_y !== e.y) begin
            $error("quat_y expected %0d got %0d", e.y, out_ch.quat_y);
            errors++;
          end
          if (out_ch.quat_z !== e.z) begin
            $error("quat_z expected %0d got %0d", e.z, out_ch.quat_z);
            errors++;
          end
          if (out_ch.quat_w !== e.w) begin
            $error("quat_w expected %0d got %0d", e.w, out_ch.quat_w);
            errors++;
          end
        end
      end
      out_ch.ready <= calm_receiver || $urandom_range(0, 99) >= 24;
    end
  end

  initial begin
    angles_t a;
    logic signed [15:0] corners[7];
    hold_sender = 0;
    calm_sender = 0;
    calm_receiver = 0;
    rst_n = 1'b0;
    corners = '{16'sd0, 16'sd25736, -16'sd25736, 16'sh7fff, -16'sh8000, 16'sd25735, 16'sd12868};

    // directed: range edges, half angle just past pi/2, full 16-bit extremes
    for (int i = 0; i < 7; i++) begin
      a.roll = corners[i];
      a.pitch = corners[(i + 2) % 7];
      a.yaw = corners[(i + 4) % 7];
      pending_angles.push_back(a);
    end
    for (int i = 0; i < 7; i++) begin
      a.roll = corners[i];
      a.pitch = corners[i];
      a.yaw = corners[i];
      pending_angles.push_back(a);
    end
    a = '{16'sd1, -16'sd1, 16'sd0};
    pending_angles.push_back(a);
    a = '{16'sh5555, 16'shAAAA, -16'sd25737};
    pending_angles.push_back(a);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 950; i++) begin
      a.roll = rand_angle();
      a.pitch = rand_angle();
      a.yaw = rand_angle();
      pending_angles.push_back(a);
      if (i == 300) begin
        while (pending_angles.size() != 0) @(posedge clk);
        hold_sender <= 1'b1;
        while (expected_quats.size() != 0) @(posedge clk);
        hold_sender <= 1'b0;
      end
      if (i == 500) begin
        calm_sender <= 1'b1;
        calm_receiver <= 1'b1;
      end
      if (i == 700) begin
        while (pending_angles.size() != 0) @(posedge clk);
        calm_sender <= 1'b0;
        calm_receiver <= 1'b0;
      end
    end
    while (pending_angles.size() != 0) @(posedge clk);
    @(posedge clk);
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
